[sv/tdpt_pkg.sv]
// Shared types and constants for the trial division prime test core.
package tdpt_pkg;

    // Width of the candidate word on the input port.
    localparam int CAND_W = 32;

    // Default width of the number actually tested.
    localparam int NUM_WIDTH_DEF = 32;

    // The first trial divisor.
    localparam int FIRST_DIVISOR = 2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_NEXT,
        ST_FINISH
    } tdpt_state_t;

endpackage

[sv/trial_division_prime_test_core.sv]
// Trial division primality tester built around one shared subtract-and-compare unit.
//
//   Channel   Direction   Handshake                   Payload
//   input     in          in_valid / in_stall         candidate [31:0]
//   output    out         out_valid / out_stall       is_prime
//
// A word is taken only while the sequencer is idle. Each trial divisor d takes
// a bound check of d*d, NUM_WIDTH restoring divider steps and a step of d.
// A finished result waits only while the output register is full and stalled.
// Reset clears the sequencer and the output valid flag.
module trial_division_prime_test_core #(
    parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tdpt_pkg::CAND_W-1:0] candidate,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_prime
);

    // Divisor width: the last divisor tried is just above the square root.
    localparam int DW = (NUM_WIDTH + 1) / 2 + 1;
    // Partial remainder width: one bit more than the divisor.
    localparam int RW = DW + 1;
    // Width of the running square of the divisor.
    localparam int SW = NUM_WIDTH + 2;
    // Width of the divider bit counter.
    localparam int CW = $clog2(NUM_WIDTH);

    tdpt_pkg::tdpt_state_t state_reg, state_next;

    logic [NUM_WIDTH-1:0] num_reg, num_next;
    logic [DW-1:0]        div_reg, div_next;
    logic [SW-1:0]        sq_reg, sq_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 prime_reg, prime_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 is_prime_reg, is_prime_next;

    // Shared unit: the shifted partial remainder compared with and reduced by
    // the divisor.
    logic [RW-1:0] rem_shift;
    logic [RW-1:0] rem_sub;
    logic          rem_ge;

    assign rem_shift = {rem_reg[RW-2:0], num_reg[cnt_reg]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_sub   = rem_shift - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        div_reg      <= div_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        prime_reg    <= prime_next;
        is_prime_reg <= is_prime_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        prime_next     = prime_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg;

        // The downstream side takes the waiting result.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    num_next   = candidate[NUM_WIDTH-1:0];
                    div_next   = DW'(tdpt_pkg::FIRST_DIVISOR);
                    sq_next    = SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK:
            begin
                if (num_reg < NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR))
                begin
                    // Zero and one are not prime.
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_FINISH;
                end
                else if (sq_reg > {2'b00, num_reg})
                begin
                    // Every divisor up to the square root left a remainder.
                    prime_next = 1'b1;
                    state_next = tdpt_pkg::ST_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CW'(NUM_WIDTH - 1);
                    state_next = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV:
            begin
                rem_next = rem_ge ? rem_sub : rem_shift;
                if (cnt_reg == '0)
                begin
                    state_next = tdpt_pkg::ST_NEXT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            tdpt_pkg::ST_NEXT:
            begin
                if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_FINISH;
                end
                else
                begin
                    // (d + 1)^2 = d^2 + 2d + 1
                    sq_next    = sq_reg + SW'({div_reg, 1'b1});
                    div_next   = div_reg + 1'b1;
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = prime_reg;
                    state_next     = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != tdpt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule
